// ----- design/mtbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mtbd_pkg
// Types and constants shared by the multi-tap button decoder files.
// ----------------------------------------------------------------------------
package mtbd_pkg;

   localparam int CNT_W   = 16;
   localparam int PRESS_W = 4;
   localparam int ACT_W   = 4;

   localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

   localparam logic [CNT_W-1:0] CLICK_GAP_RESET = 16'd15;
   localparam logic [CNT_W-1:0] HOLD_RESET      = 16'd300;

   // register index, taken from paddr bit 2
   localparam logic REG_CLICK_GAP = 1'b0;
   localparam logic REG_HOLD      = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PRESS_W-1:0] TAPS_TOGGLE = 4'd2;
   localparam logic [PRESS_W-1:0] TAPS_PROG   = 4'd3;
   localparam logic [PRESS_W-1:0] TAPS_LINK   = 4'd4;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE         = 4'd0,
      ACT_HEAD_TOGGLE  = 4'd1,
      ACT_BODY_STIFF   = 4'd2,
      ACT_BODY_LIMP    = 4'd3,
      ACT_REBOOT       = 4'd4,
      ACT_START        = 4'd5,
      ACT_STOP         = 4'd6,
      ACT_LINK_RESTART = 4'd7,
      ACT_SHUTDOWN     = 4'd8
   } mtbd_action_type;

   typedef struct packed {
      logic button_down;
      logic bumper_down;
      logic program_absent;
   } mtbd_req_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [PRESS_W-1:0] tap_count;
      logic               body_limp;
      logic               head_relax;
   } mtbd_rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] click_gap_ticks;
      logic [CNT_W-1:0] hold_ticks;
   } mtbd_cfg_type;

endpackage

// ----- design/mtbd_csr.sv -----
// ----------------------------------------------------------------------------
// mtbd_csr
// APB-style register file holding the click gap and hold thresholds.
// ----------------------------------------------------------------------------
module mtbd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mtbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mtbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mtbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output mtbd_pkg::mtbd_cfg_type              cfg
);
   import mtbd_pkg::*;

   logic [CNT_W-1:0] click_gap_ff, click_gap_in;
   logic [CNT_W-1:0] hold_ff, hold_in;
   logic             wr_en;
   logic             reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      click_gap_in = click_gap_ff;
      hold_in      = hold_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CLICK_GAP: click_gap_in = csr_pwdata[CNT_W-1:0];
            REG_HOLD:      hold_in      = csr_pwdata[CNT_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         click_gap_ff <= CLICK_GAP_RESET;
         hold_ff      <= HOLD_RESET;
      end else begin
         click_gap_ff <= click_gap_in;
         hold_ff      <= hold_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CLICK_GAP: csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, click_gap_ff};
         REG_HOLD:      csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, hold_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.click_gap_ticks = click_gap_ff;
   assign cfg.hold_ticks      = hold_ff;

endmodule

// ----- design/multi_tap_button_decoder.sv -----
// ----------------------------------------------------------------------------
// multi_tap_button_decoder
// Counts button presses per tick, decodes multi-tap gestures into actions
// and raises a one-time shutdown on a long hold.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat
//  req     | in        | req_valid/req_ready | mtbd_req_type (one tick sample)
//  rsp     | out       | rsp_valid/rsp_ready | mtbd_rsp_type (one result)
//  csr     | in/out    | psel/penable/pready | 32-bit register access
//
// One beat per clock while req_ready is high; each req beat gives one rsp beat.
// The decode and counter update run in a single pass between the state
// registers and a two-entry output buffer (result register plus skid).
// req_ready is low only while the skid entry is full.
// Synchronous reset restores thresholds 15 and 300, body limp set.
// ----------------------------------------------------------------------------
module multi_tap_button_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mtbd_pkg::mtbd_req_type           req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mtbd_pkg::mtbd_rsp_type           rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mtbd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mtbd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mtbd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import mtbd_pkg::*;

   mtbd_cfg_type cfg;

   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   released_ff, released_in;
   logic [PRESS_W-1:0] press_ff, press_in;
   logic               shut_ff, shut_in;
   logic               body_ff, body_in;
   logic               head_ff, head_in;

   mtbd_rsp_type       result;
   mtbd_rsp_type       out_ff, out_in;
   mtbd_rsp_type       skid_ff, skid_in;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               out_take;
   logic               decode;
   logic [ACT_W-1:0]   action;

   mtbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = out_valid_ff && rsp_ready;

   // tap decode, shutdown check, then counter update with this tick's level
   always_comb begin
      held_in     = held_ff;
      released_in = released_ff;
      press_in    = press_ff;
      shut_in     = shut_ff;
      body_in     = body_ff;
      head_in     = head_ff;
      action      = ACT_NONE;

      decode = (released_ff > cfg.click_gap_ticks) && (press_ff != '0);
      if (decode) begin
         press_in = '0;
         case (press_ff)
            TAPS_TOGGLE: begin
               if (req_payload.bumper_down) begin
                  head_in = !head_ff;
                  action  = ACT_HEAD_TOGGLE;
               end else if (body_ff) begin
                  body_in = 1'b0;
                  action  = ACT_BODY_STIFF;
               end else begin
                  body_in = 1'b1;
                  action  = ACT_BODY_LIMP;
               end
            end
            TAPS_PROG: begin
               if (req_payload.bumper_down) begin
                  action = ACT_REBOOT;
               end else if (req_payload.program_absent) begin
                  action = ACT_START;
               end else begin
                  action = ACT_STOP;
               end
            end
            TAPS_LINK: action = ACT_LINK_RESTART;
            default:   action = ACT_NONE;
         endcase
      end

      if (!shut_ff && (held_ff > cfg.hold_ticks)) begin
         action  = ACT_SHUTDOWN;
         body_in = 1'b1;
         shut_in = 1'b1;
         held_in = '0;
      end

      if (req_payload.button_down) begin
         if (!shut_in && (held_in != CNT_MAX)) begin
            held_in = held_in + 1'b1;
         end
         released_in = '0;
      end else begin
         if (released_ff != CNT_MAX) begin
            released_in = released_ff + 1'b1;
         end
         if (!shut_in && (held_in != '0)) begin
            if (press_in != PRESS_MAX) begin
               press_in = press_in + 1'b1;
            end
            held_in = '0;
         end
      end

      result.action     = action;
      result.tap_count  = decode ? press_ff : '0;
      result.body_limp  = body_in;
      result.head_relax = head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         released_ff <= '0;
         press_ff    <= '0;
         shut_ff     <= 1'b0;
         body_ff     <= 1'b1;
         head_ff     <= 1'b0;
      end else if (accept) begin
         held_ff     <= held_in;
         released_ff <= released_in;
         press_ff    <= press_in;
         shut_ff     <= shut_in;
         body_ff     <= body_in;
         head_ff     <= head_in;
      end
   end

   // two-entry output buffer: result register with a skid entry behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) begin
         out_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat while the result register is empty");

   a_shut_sticky: assert property (@(posedge clock) disable iff (reset)
      shut_ff |=> shut_ff)
      else $error("shutdown latch cleared without reset");

   a_shut_no_hold: assert property (@(posedge clock) disable iff (reset)
      shut_ff |-> (held_ff == '0))
      else $error("held count moving after shutdown latched");

   a_action_has_taps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.action != ACT_NONE)
                 && (rsp_payload.action != ACT_SHUTDOWN))
      |-> (rsp_payload.tap_count != '0))
      else $error("tap action reported without a decoded tap count");

   a_shut_forces_limp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.action == ACT_SHUTDOWN)) |-> rsp_payload.body_limp)
      else $error("shutdown beat without body limp");
`endif

endmodule
